// ===== hw/rtl/bph_pkg.sv =====
// bph_pkg: shared types and constants for the bit pattern histogram
// used by bph_cell and bit_pattern_histogram; depends on nothing

package bph_pkg;

  // fixed widths of the beat fields and config registers
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned PAT_W     = 12;
  localparam int unsigned LEN_CMP_W = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 4;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b1;

  // request codes
  localparam logic REQ_FEED = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_UPD_RD,
    S_UPD_WR,
    S_Q_RD,
    S_Q_OUT
  } state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                 clear;
    logic                 shift;
    logic                 upd_rd;
    logic                 upd_wr;
    logic                 q_rd;
    logic [LEN_CMP_W-1:0] lo;
    logic [LEN_CMP_W-1:0] hi;
    logic [LEN_CMP_W-1:0] q_len;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/bit_pattern_histogram.sv =====
// bit_pattern_histogram: top level, sequencer and the row of length cells
// depends on bph_pkg, bph_cell and bph_ram
//
//  channel | ports                                              | direction
//  in      | in_valid in_ready in_req_type in_bit_value          | in
//          | in_query_length in_query_pattern                    |
//  out     | out_valid out_ready out_pattern_count               | out
//  cfg     | cfg_we cfg_addr cfg_wdata                           | in
//
// a fed bit passes through accept, bank read and bank write, set by the
// read-modify-write of the per-length counter banks; a read passes through
// accept, bank read and result load when the output register is free
// after reset a clearing sweep runs through every bank address with in_ready low
// a stalled result holds the sequencer in its last read step; feed beats
// are still taken while an earlier result waits in the output register

module bit_pattern_histogram #(
  parameter int unsigned MAX_LEN    = 12,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic                              in_bit_value,
  input  logic [bph_pkg::LEN_W-1:0]         in_query_length,
  input  logic [bph_pkg::PAT_W-1:0]         in_query_pattern,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COUNT_BITS-1:0]             out_pattern_count,
  input  logic                              cfg_we,
  input  logic [bph_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [bph_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  localparam int unsigned CW = bph_pkg::LEN_CMP_W;

  bph_pkg::state_t     state_r, state_nxt;
  bph_pkg::cell_ctrl_t ctrl;

  logic [bph_pkg::CFG_DAT_W-1:0] min_len_r;
  logic [bph_pkg::CFG_DAT_W-1:0] max_len_r;
  logic [MAX_LEN-1:0]            clr_cnt_r;
  logic [bph_pkg::LEN_W-1:0]     q_len_r;
  logic [MAX_LEN-1:0]            q_pat_r;
  logic [MAX_LEN+bph_pkg::PAT_W-1:0] q_pat_ext;
  logic                          out_valid_r;
  logic [COUNT_BITS-1:0]         out_count_r;
  logic                          out_load;
  logic                          in_fire;
  logic [CW-1:0]                 min_ext;
  logic [CW-1:0]                 max_ext;

  logic                  bit_chain  [MAX_LEN+1];
  logic                  seen_chain [MAX_LEN+1];
  logic [MAX_LEN-1:0]    pat_chain  [MAX_LEN+1];
  logic [COUNT_BITS-1:0] cell_count [MAX_LEN];
  logic [COUNT_BITS-1:0] count_or;

  assign in_fire = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= bph_pkg::CFG_DAT_W'(1);
      max_len_r <= bph_pkg::CFG_DAT_W'(12);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bph_pkg::CFG_MIN_LEN: min_len_r <= cfg_wdata;
        bph_pkg::CFG_MAX_LEN: max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective length range: zero min acts as one, max clamps to MAX_LEN
  assign min_ext = CW'(min_len_r);
  assign max_ext = CW'(max_len_r);

  // captured query, pattern widened or cut to the window width
  assign q_pat_ext = {{MAX_LEN{1'b0}}, in_query_pattern};

  always_ff @(posedge clk) begin
    if (in_fire && (in_req_type == bph_pkg::REQ_READ)) begin
      q_len_r <= in_query_length;
      q_pat_r <= q_pat_ext[MAX_LEN-1:0];
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (state_r == bph_pkg::S_CLR) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bph_pkg::S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and cell controls
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    ctrl.clear  = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.upd_rd = 1'b0;
    ctrl.upd_wr = 1'b0;
    ctrl.q_rd   = 1'b0;
    ctrl.lo     = (min_ext == '0) ? CW'(1) : min_ext;
    ctrl.hi     = (max_ext > CW'(MAX_LEN)) ? CW'(MAX_LEN) : max_ext;
    ctrl.q_len  = CW'(q_len_r);
    unique case (state_r)
      bph_pkg::S_CLR: begin
        ctrl.clear = 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = bph_pkg::S_IDLE;
        end
      end
      bph_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == bph_pkg::REQ_FEED) begin
            ctrl.shift = 1'b1;
            state_nxt  = bph_pkg::S_UPD_RD;
          end else begin
            state_nxt  = bph_pkg::S_Q_RD;
          end
        end
      end
      bph_pkg::S_UPD_RD: begin
        ctrl.upd_rd = 1'b1;
        state_nxt   = bph_pkg::S_UPD_WR;
      end
      bph_pkg::S_UPD_WR: begin
        ctrl.upd_wr = 1'b1;
        state_nxt   = bph_pkg::S_IDLE;
      end
      bph_pkg::S_Q_RD: begin
        ctrl.q_rd = 1'b1;
        state_nxt = bph_pkg::S_Q_OUT;
      end
      bph_pkg::S_Q_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = bph_pkg::S_IDLE;
        end
      end
      default: state_nxt = bph_pkg::S_IDLE;
    endcase
  end

  // row of cells, one per pattern length
  assign bit_chain[0]  = in_bit_value;
  assign seen_chain[0] = 1'b1;
  assign pat_chain[0]  = '0;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    bph_cell #(
      .LEN        (i + 1),
      .MAX_LEN    (MAX_LEN),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .clr_addr  (clr_cnt_r),
      .q_pat     (q_pat_r),
      .bit_in    (bit_chain[i]),
      .seen_in   (seen_chain[i]),
      .pat_in    (pat_chain[i]),
      .bit_out   (bit_chain[i+1]),
      .seen_out  (seen_chain[i+1]),
      .pat_out   (pat_chain[i+1]),
      .count_out (cell_count[i])
    );
  end

  // at most one cell drives a nonzero count
  always_comb begin
    count_or = '0;
    for (int i = 0; i < MAX_LEN; i++) begin
      count_or = count_or | cell_count[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= count_or;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pattern_count = out_count_r;

  // no beat is taken while the banks are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bph_pkg::S_CLR) |-> !in_ready)
    else $error("input accepted during clearing sweep");

  // a fed bit passes through the bank read step to the bank write after acceptance
  a_feed_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_req_type == bph_pkg::REQ_FEED)) |=> ##1 (state_r == bph_pkg::S_UPD_WR))
    else $error("feed did not reach the bank write step");

  // a read passes through the bank read step to the result step after acceptance
  a_query_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_req_type == bph_pkg::REQ_READ)) |=> ##1 (state_r == bph_pkg::S_Q_OUT))
    else $error("read did not reach the result step");

  // a pending result waits while the output register is still occupied
  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == bph_pkg::S_Q_OUT) && out_valid_r && !out_ready) |=>
      ((state_r == bph_pkg::S_Q_OUT) && out_valid_r))
    else $error("result overwrote an unaccepted beat");

endmodule

// ===== hw/rtl/bph_ram.sv =====
// bph_ram: generic simple dual port RAM, one write and one registered read
// depends on nothing

module bph_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bph_cell.sv =====
// bph_cell: one window bit plus the counter bank for patterns of length LEN
// depends on bph_pkg and bph_ram

module bph_cell #(
  parameter int unsigned LEN        = 1,
  parameter int unsigned MAX_LEN    = 12,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bph_pkg::cell_ctrl_t     ctrl,
  input  logic [MAX_LEN-1:0]      clr_addr,
  input  logic [MAX_LEN-1:0]      q_pat,
  input  logic                    bit_in,
  input  logic                    seen_in,
  input  logic [MAX_LEN-1:0]      pat_in,
  output logic                    bit_out,
  output logic                    seen_out,
  output logic [MAX_LEN-1:0]      pat_out,
  output logic [COUNT_BITS-1:0]   count_out
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [bph_pkg::LEN_CMP_W-1:0] MY_LEN = bph_pkg::LEN_CMP_W'(LEN);

  logic                  bit_r;
  logic                  seen_r;
  logic [LEN-1:0]        pattern;
  logic                  count_en;
  logic                  ram_we;
  logic [LEN-1:0]        ram_wa;
  logic [COUNT_BITS-1:0] ram_wd;
  logic [LEN-1:0]        ram_ra;
  logic [COUNT_BITS-1:0] ram_rd;

  // window bit and fill flag shift one cell up on every fed bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r  <= 1'b0;
      seen_r <= 1'b0;
    end else if (ctrl.shift) begin
      bit_r  <= bit_in;
      seen_r <= seen_in;
    end
  end

  assign bit_out  = bit_r;
  assign seen_out = seen_r;

  // pattern ending at the newest bit: lower cells fill the low bits
  always_comb begin
    pat_out          = pat_in;
    pat_out[LEN-1]   = bit_r;
  end
  assign pattern = pat_out[LEN-1:0];

  // this length counts once its window is full and it is in range
  assign count_en = seen_r && (MY_LEN >= ctrl.lo) && (MY_LEN <= ctrl.hi);

  // bank access: clear sweep, read-modify-write update, query read
  assign ram_ra = ctrl.q_rd ? q_pat[LEN-1:0] : pattern;
  assign ram_we = ctrl.clear || (ctrl.upd_wr && count_en && (ram_rd != COUNT_MAX));
  assign ram_wa = ctrl.clear ? clr_addr[LEN-1:0] : pattern;
  assign ram_wd = ctrl.clear ? '0 : ram_rd + 1'b1;

  bph_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (2 ** LEN)
  ) u_bank (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ctrl.upd_rd || ctrl.q_rd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // only the cell of the queried length drives its count
  assign count_out = (ctrl.q_len == MY_LEN) ? ram_rd : '0;

endmodule
